// ===== hw/rtl/rpai_pkg.sv =====
`default_nettype none

package rpai_pkg;

  localparam logic [31:0]        DT_RESET = 32'd262;
  localparam logic signed [15:0] Q14_ONE  = 16'sd16384;
  localparam logic signed [65:0] SAT_HI   = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO   = -66'sd2147483648;

  // one record travels the whole pipeline; stages fill in its fields, and some fields are reused by several stages
  typedef struct packed {
    logic [63:0]            rot;
    logic [2:0][31:0]       w_in;
    logic [2:0][31:0]       tq;
    logic [2:0][31:0]       iner;
    logic                   skip;
    logic [2:0][31:0]       rem;
    logic [2:0][32:0]       quo;
    logic [2:0][31:0]       inv;
    logic [2:0][64:0]       prd;
    logic [2:0][31:0]       lv;
    logic [2:0][63:0]       pa;
    logic [2:0][63:0]       pb;
    logic [2:0][31:0]       pv;
    logic [2:0][31:0]       dv;
    logic [2:0][31:0]       sv;
    logic [2:0][31:0]       av;
    logic [2:0][31:0]       wn;
    logic [3:0][2:0][47:0]  qp;
    logic [3:0][49:0]       dsum;
    logic [3:0][31:0]       dq;
    logic [3:0][64:0]       mq;
    logic [3:0][31:0]       inc;
    logic [3:0][33:0]       u;
    logic [3:0][33:0]       mag;
    logic [3:0]             neg;
    logic [33:0]            maxm;
    logic                   zero;
    logic [5:0]             lead;
    logic [3:0][29:0]       nm;
    logic [3:0][59:0]       sq;
    logic [61:0]            sn;
    logic [63:0]            sres;
    logic [3:0][31:0]       drem;
    logic [3:0][14:0]       dquo;
  } pl_t;

  typedef struct packed {
    logic [63:0]      rot;
    logic [2:0][31:0] w;
    logic             skipped;
  } res_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > SAT_HI) return 32'h7FFF_FFFF;
    if (v < SAT_LO) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [64:0] mul65(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
    logic signed [64:0] ae;
    logic signed [64:0] be;
    ae = 65'(a);
    be = 65'(b);
    return ae * be;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rpai_cfg_if.sv =====
`default_nettype none

interface rpai_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] sub_step_time;

  modport source (output valid, output sub_step_time, input ready);
  modport sink   (input valid, input sub_step_time, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rpai_in_if.sv =====
`default_nettype none

interface rpai_in_if;
  logic               valid;
  logic               ready;
  logic [63:0]        rotation_in;
  logic signed [31:0] ang_vel_x;
  logic signed [31:0] ang_vel_y;
  logic signed [31:0] ang_vel_z;
  logic signed [31:0] torque_x;
  logic signed [31:0] torque_y;
  logic signed [31:0] torque_z;
  logic [31:0]        inertia_x;
  logic [31:0]        inertia_y;
  logic [31:0]        inertia_z;
  logic               pinned;

  modport source (output valid, output rotation_in, output ang_vel_x, output ang_vel_y,
                  output ang_vel_z, output torque_x, output torque_y, output torque_z,
                  output inertia_x, output inertia_y, output inertia_z, output pinned,
                  input ready);
  modport sink   (input valid, input rotation_in, input ang_vel_x, input ang_vel_y,
                  input ang_vel_z, input torque_x, input torque_y, input torque_z,
                  input inertia_x, input inertia_y, input inertia_z, input pinned,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rpai_out_if.sv =====
`default_nettype none

interface rpai_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        rotation_out;
  logic signed [31:0] new_ang_vel_x;
  logic signed [31:0] new_ang_vel_y;
  logic signed [31:0] new_ang_vel_z;
  logic               skipped;

  modport source (output valid, output rotation_out, output new_ang_vel_x,
                  output new_ang_vel_y, output new_ang_vel_z, output skipped, input ready);
  modport sink   (input valid, input rotation_out, input new_ang_vel_x,
                  input new_ang_vel_y, input new_ang_vel_z, input skipped, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rigid_point_angular_integrator_top.sv =====
// Throughput: one transaction per cycle while the output buffer has room;
// 33 reciprocal stages, a 32-stage square root and 15 normalising divide stages
// set the depth, each one bit per stage.
// A two-entry output buffer keeps the pipeline moving while a result waits.
// Reset (rst_n low, synchronous) empties the pipeline and buffer; sub_step_time = 262.
`default_nettype none

module rigid_point_angular_integrator_top
  import rpai_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rpai_cfg_if.sink    cfg_ch,
  rpai_in_if.sink     in_ch,
  rpai_out_if.source  out_ch
);

  localparam int V_INV    = 33;
  localparam int V_L      = 34;
  localparam int V_CROSS  = 35;
  localparam int V_P      = 36;
  localparam int V_D      = 37;
  localparam int V_MDT    = 38;
  localparam int V_SDT    = 39;
  localparam int V_MINV   = 40;
  localparam int V_ACC    = 41;
  localparam int V_W      = 42;
  localparam int Q_PROD   = 43;
  localparam int Q_SUM    = 44;
  localparam int Q_DQ     = 45;
  localparam int Q_MDT    = 46;
  localparam int Q_INC    = 47;
  localparam int Q_U      = 48;
  localparam int Q_MAG    = 49;
  localparam int Q_MAX    = 50;
  localparam int Q_LEAD   = 51;
  localparam int Q_NORM   = 52;
  localparam int Q_SQ     = 53;
  localparam int Q_N2     = 54;
  localparam int SQ_FIRST = 55;
  localparam int DV_FIRST = 87;
  localparam int NST      = 102;

  logic [31:0]    sub_step_time_r;
  pl_t            in_item;
  pl_t            pipe_r [NST];
  pl_t            stg_nxt [NST];
  logic [NST-1:0] vld_r;
  logic           en;
  res_t           fin;
  res_t           buf0_r;
  res_t           buf1_r;
  logic [1:0]     cnt_r;
  logic           push;
  logic           pop;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_step_time_r <= DT_RESET;
    end else if (cfg_ch.valid) begin
      sub_step_time_r <= cfg_ch.sub_step_time;
    end
  end

  assign en          = (cnt_r != 2'd2);
  assign in_ch.ready = en;

  always_comb begin
    in_item         = '0;
    in_item.rot     = in_ch.rotation_in;
    in_item.w_in[0] = in_ch.ang_vel_x;
    in_item.w_in[1] = in_ch.ang_vel_y;
    in_item.w_in[2] = in_ch.ang_vel_z;
    in_item.tq[0]   = in_ch.torque_x;
    in_item.tq[1]   = in_ch.torque_y;
    in_item.tq[2]   = in_ch.torque_z;
    in_item.iner[0] = in_ch.inertia_x;
    in_item.iner[1] = in_ch.inertia_y;
    in_item.iner[2] = in_ch.inertia_z;
    in_item.skip    = in_ch.pinned | ((in_ch.inertia_x == '0) & (in_ch.inertia_y == '0)
                                      & (in_ch.inertia_z == '0));
  end

  for (genvar k = 0; k < NST; k++) begin : g_stg
    pl_t src;

    if (k == 0) begin : g_head
      assign src = in_item;
    end else begin : g_body
      assign src = pipe_r[k-1];
    end

    always_comb begin
      pl_t          p;
      logic [32:0]  rs;
      logic         ge;
      logic [63:0]  bitv;
      logic [63:0]  tsum;
      logic [15:0]  qv;
      p    = src;
      rs   = '0;
      ge   = 1'b0;
      bitv = '0;
      tsum = '0;
      qv   = '0;
      if (k < V_INV) begin
        // reciprocal 2^32 / inertia, one quotient bit per stage
        for (int i = 0; i < 3; i++) begin
          rs = {p.rem[i], 1'(k == 0)};
          ge = (rs >= {1'b0, p.iner[i]});
          p.rem[i] = ge ? 32'(rs - {1'b0, p.iner[i]}) : rs[31:0];
          p.quo[i] = {p.quo[i][31:0], ge};
        end
      end else if (k == V_INV) begin
        for (int i = 0; i < 3; i++) begin
          if (p.iner[i] == '0) begin
            p.inv[i] = '0;
          end else if (p.quo[i][32]) begin
            p.inv[i] = '1;
          end else begin
            p.inv[i] = p.quo[i][31:0];
          end
          p.prd[i] = mul65(33'($signed(p.w_in[i])), $signed({1'b0, p.iner[i]}));
        end
      end else if (k == V_L) begin
        for (int i = 0; i < 3; i++) p.lv[i] = sat32(66'($signed(p.prd[i]) >>> 16));
      end else if (k == V_CROSS) begin
        p.pa[0] = 64'(mul65(33'($signed(p.w_in[1])), 33'($signed(p.lv[2]))));
        p.pb[0] = 64'(mul65(33'($signed(p.w_in[2])), 33'($signed(p.lv[1]))));
        p.pa[1] = 64'(mul65(33'($signed(p.w_in[2])), 33'($signed(p.lv[0]))));
        p.pb[1] = 64'(mul65(33'($signed(p.w_in[0])), 33'($signed(p.lv[2]))));
        p.pa[2] = 64'(mul65(33'($signed(p.w_in[0])), 33'($signed(p.lv[1]))));
        p.pb[2] = 64'(mul65(33'($signed(p.w_in[1])), 33'($signed(p.lv[0]))));
      end else if (k == V_P) begin
        for (int i = 0; i < 3; i++) begin
          p.pv[i] = sat32(66'($signed(p.pa[i]) >>> 16) - 66'($signed(p.pb[i]) >>> 16));
        end
      end else if (k == V_D) begin
        for (int i = 0; i < 3; i++) begin
          p.dv[i] = sat32(66'($signed(p.tq[i])) - 66'($signed(p.pv[i])));
        end
      end else if (k == V_MDT) begin
        for (int i = 0; i < 3; i++) begin
          p.prd[i] = mul65($signed({1'b0, sub_step_time_r}), 33'($signed(p.dv[i])));
        end
      end else if (k == V_SDT) begin
        for (int i = 0; i < 3; i++) p.sv[i] = sat32(66'($signed(p.prd[i]) >>> 16));
      end else if (k == V_MINV) begin
        for (int i = 0; i < 3; i++) begin
          p.prd[i] = mul65(33'($signed(p.sv[i])), $signed({1'b0, p.inv[i]}));
        end
      end else if (k == V_ACC) begin
        for (int i = 0; i < 3; i++) p.av[i] = sat32(66'($signed(p.prd[i]) >>> 16));
      end else if (k == V_W) begin
        for (int i = 0; i < 3; i++) begin
          p.wn[i] = sat32(66'($signed(p.w_in[i])) + 66'($signed(p.av[i])));
        end
      end else if (k == Q_PROD) begin
        for (int i = 0; i < 4; i++) begin
          qv = p.rot[63-16*i -: 16];
          for (int j = 0; j < 3; j++) begin
            p.qp[i][j] = 48'(mul65(33'($signed(qv)), 33'($signed(p.wn[j]))));
          end
        end
      end else if (k == Q_SUM) begin
        // q * (0, omega)
        p.dsum[0] = 50'(-($signed(p.qp[1][0]) + $signed(p.qp[2][1]) + $signed(p.qp[3][2])));
        p.dsum[1] = 50'($signed(p.qp[0][0]) + $signed(p.qp[2][2]) - $signed(p.qp[3][1]));
        p.dsum[2] = 50'($signed(p.qp[0][1]) + $signed(p.qp[3][0]) - $signed(p.qp[1][2]));
        p.dsum[3] = 50'($signed(p.qp[0][2]) + $signed(p.qp[1][1]) - $signed(p.qp[2][0]));
      end else if (k == Q_DQ) begin
        for (int i = 0; i < 4; i++) p.dq[i] = sat32(66'($signed(p.dsum[i]) >>> 14));
      end else if (k == Q_MDT) begin
        for (int i = 0; i < 4; i++) begin
          p.mq[i] = mul65($signed({1'b0, sub_step_time_r}), 33'($signed(p.dq[i])));
        end
      end else if (k == Q_INC) begin
        for (int i = 0; i < 4; i++) p.inc[i] = sat32(66'($signed(p.mq[i]) >>> 17));
      end else if (k == Q_U) begin
        for (int i = 0; i < 4; i++) begin
          qv = p.rot[63-16*i -: 16];
          p.u[i] = (34'($signed(qv)) <<< 2) + 34'($signed(p.inc[i]));
        end
      end else if (k == Q_MAG) begin
        for (int i = 0; i < 4; i++) begin
          p.neg[i] = p.u[i][33];
          p.mag[i] = p.u[i][33] ? 34'(34'd0 - p.u[i]) : p.u[i];
        end
      end else if (k == Q_MAX) begin
        p.maxm = p.mag[0];
        for (int i = 1; i < 4; i++) begin
          if (p.mag[i] > p.maxm) p.maxm = p.mag[i];
        end
        p.zero = (p.maxm == '0);
      end else if (k == Q_LEAD) begin
        p.lead = '0;
        for (int b = 0; b < 34; b++) begin
          if (p.maxm[b]) p.lead = 6'(b);
        end
      end else if (k == Q_NORM) begin
        // bring the largest magnitude into [2^29, 2^30)
        for (int i = 0; i < 4; i++) begin
          if (p.lead >= 6'd29) begin
            p.nm[i] = 30'(p.mag[i] >> (p.lead - 6'd29));
          end else begin
            p.nm[i] = 30'(p.mag[i] << (6'd29 - p.lead));
          end
        end
      end else if (k == Q_SQ) begin
        for (int i = 0; i < 4; i++) p.sq[i] = 60'(p.nm[i]) * 60'(p.nm[i]);
      end else if (k == Q_N2) begin
        p.sn   = 62'(p.sq[0]) + 62'(p.sq[1]) + 62'(p.sq[2]) + 62'(p.sq[3]);
        p.sres = '0;
      end else if (k < DV_FIRST) begin
        // integer square root, one result bit per stage
        bitv = 64'(1) << (62 - 2 * (k - SQ_FIRST));
        tsum = p.sres + bitv;
        if (64'(p.sn) >= tsum) begin
          p.sn   = 62'(64'(p.sn) - tsum);
          p.sres = (p.sres >> 1) + bitv;
        end else begin
          p.sres = p.sres >> 1;
        end
      end else begin
        // component * 2^14 / length, one quotient bit per stage
        for (int i = 0; i < 4; i++) begin
          if (k == DV_FIRST) begin
            rs = {3'b000, p.nm[i][29:1], p.nm[i][0]};
          end else begin
            rs = {p.drem[i], 1'b0};
          end
          ge = (rs >= {1'b0, p.sres[31:0]});
          p.drem[i] = ge ? 32'(rs - {1'b0, p.sres[31:0]}) : rs[31:0];
          p.dquo[i] = {p.dquo[i][13:0], ge};
        end
      end
      stg_nxt[k] = p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) pipe_r[k] <= stg_nxt[k];
    end
  end

  // result assembly from the last stage
  always_comb begin
    logic [15:0] c;
    c   = '0;
    fin = '0;
    if (pipe_r[NST-1].skip) begin
      fin.rot     = pipe_r[NST-1].rot;
      fin.w       = pipe_r[NST-1].w_in;
      fin.skipped = 1'b1;
    end else begin
      if (pipe_r[NST-1].zero) begin
        fin.rot = {Q14_ONE, 48'd0};
      end else begin
        for (int i = 0; i < 4; i++) begin
          c = {1'b0, pipe_r[NST-1].dquo[i]};
          fin.rot[63-16*i -: 16] = pipe_r[NST-1].neg[i] ? 16'(16'd0 - c) : c;
        end
      end
      fin.w       = pipe_r[NST-1].wn;
      fin.skipped = 1'b0;
    end
  end

  assign push = en && vld_r[NST-1];
  assign pop  = out_ch.ready && (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      priority if (push && !pop) begin
        if (cnt_r == 2'd0) buf0_r <= fin;
        else buf1_r <= fin;
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        buf0_r <= buf1_r;
        cnt_r  <= cnt_r - 2'd1;
      end else if (push && pop) begin
        // hold the count: the new transaction replaces the one leaving
        if (cnt_r == 2'd1) buf0_r <= fin;
        else begin
          buf0_r <= buf1_r;
          buf1_r <= fin;
        end
      end
    end
  end

  assign out_ch.valid         = (cnt_r != 2'd0);
  assign out_ch.rotation_out  = buf0_r.rot;
  assign out_ch.new_ang_vel_x = buf0_r.w[0];
  assign out_ch.new_ang_vel_y = buf0_r.w[1];
  assign out_ch.new_ang_vel_z = buf0_r.w[2];
  assign out_ch.skipped       = buf0_r.skipped;

  function automatic logic rot_ok(input logic [63:0] r);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if ($signed(r[63-16*i -: 16]) > Q14_ONE || $signed(r[63-16*i -: 16]) < -Q14_ONE) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (vld_r[NST-1] && !en) |=> (vld_r[NST-1] && $stable(pipe_r[NST-1].rot)))
    else $error("stalled last stage lost its transaction");

  a_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
      (out_ch.valid && !out_ch.skipped) |-> rot_ok(out_ch.rotation_out))
    else $error("normalised quaternion component out of range");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
      (push && !pop) |=> out_ch.valid)
    else $error("pushed result not presented");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import rpai_pkg::*;

  typedef struct packed {
    logic [63:0]      rot;
    logic [2:0][31:0] w;
    logic [2:0][31:0] tq;
    logic [2:0][31:0] iner;
    logic             pinned;
  } point_t;

  localparam int SETTLE_CYCLES = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rpai_cfg_if cfg_ch ();
  rpai_in_if  in_ch ();
  rpai_out_if out_ch ();

  rigid_point_angular_integrator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  point_t      point_queue[$];
  res_t        expected_points[$];
  point_t      point_on_bus;
  logic [31:0] dt_model = DT_RESET;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          errors = 0;

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.sub_step_time = '0;
    in_ch.valid = 1'b0;
    in_ch.rotation_in = '0;
    in_ch.ang_vel_x = '0;
    in_ch.ang_vel_y = '0;
    in_ch.ang_vel_z = '0;
    in_ch.torque_x = '0;
    in_ch.torque_y = '0;
    in_ch.torque_z = '0;
    in_ch.inertia_x = '0;
    in_ch.inertia_y = '0;
    in_ch.inertia_z = '0;
    in_ch.pinned = 1'b0;
    out_ch.ready = 1'b0;
    point_on_bus = '0;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mul_q16(input longint a, input longint b);
    return clamp32((a * b) >>> 16);
  endfunction

  function automatic longint root_floor(input longint n);
    longint res;
    longint bitv;
    res = 0;
    bitv = 64'sd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic res_t integrate_point(input point_t p, input logic [31:0] dt_reg);
    longint w[3], t[3], ine[3], inv[3], lv[3], pv[3];
    longint q[4], d[4], u[4], mag[4];
    bit     ng[4];
    longint dt, maxm, n2, len, c, dq, inc;
    res_t   r;
    dt = longint'({32'd0, dt_reg});
    for (int i = 0; i < 3; i++) begin
      w[i] = longint'($signed(p.w[i]));
      t[i] = longint'($signed(p.tq[i]));
      ine[i] = longint'({32'd0, p.iner[i]});
    end
    r.rot = p.rot;
    r.skipped = 1'b1;
    for (int i = 0; i < 3; i++) r.w[i] = p.w[i];
    if (p.pinned || (ine[0] == 0 && ine[1] == 0 && ine[2] == 0)) return r;
    r.skipped = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (ine[i] == 0) inv[i] = 0;
      else begin
        inv[i] = (64'sd1 << 32) / ine[i];
        if (inv[i] > 64'sh0FFFF_FFFF) inv[i] = 64'sh0FFFF_FFFF;
      end
      lv[i] = mul_q16(w[i], ine[i]);
    end
    pv[0] = clamp32(((w[1] * lv[2]) >>> 16) - ((w[2] * lv[1]) >>> 16));
    pv[1] = clamp32(((w[2] * lv[0]) >>> 16) - ((w[0] * lv[2]) >>> 16));
    pv[2] = clamp32(((w[0] * lv[1]) >>> 16) - ((w[1] * lv[0]) >>> 16));
    for (int i = 0; i < 3; i++)
      w[i] = clamp32(w[i] + mul_q16(mul_q16(dt, clamp32(t[i] - pv[i])), inv[i]));
    for (int i = 0; i < 4; i++) q[i] = longint'($signed(p.rot[63 - 16 * i -: 16]));
    d[0] = -(q[1] * w[0] + q[2] * w[1] + q[3] * w[2]);
    d[1] = q[0] * w[0] + q[2] * w[2] - q[3] * w[1];
    d[2] = q[0] * w[1] + q[3] * w[0] - q[1] * w[2];
    d[3] = q[0] * w[2] + q[1] * w[1] - q[2] * w[0];
    maxm = 0;
    for (int i = 0; i < 4; i++) begin
      dq = clamp32(d[i] >>> 14);
      inc = clamp32((dt * dq) >>> 17);
      u[i] = q[i] * 4 + inc;
      ng[i] = u[i] < 0;
      mag[i] = ng[i] ? -u[i] : u[i];
      if (mag[i] > maxm) maxm = mag[i];
    end
    for (int i = 0; i < 3; i++) r.w[i] = w[i][31:0];
    if (maxm == 0) begin
      r.rot = {Q14_ONE, 48'd0};
      return r;
    end
    while (maxm >= (64'sd1 << 30)) begin
      maxm = maxm >> 1;
      for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 1;
    end
    while (maxm < (64'sd1 << 29)) begin
      maxm = maxm << 1;
      for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
    end
    n2 = 0;
    for (int i = 0; i < 4; i++) n2 = n2 + mag[i] * mag[i];
    len = root_floor(n2);
    for (int i = 0; i < 4; i++) begin
      c = (mag[i] << 14) / len;
      if (ng[i]) c = -c;
      r.rot[63 - 16 * i -: 16] = c[15:0];
    end
    return r;
  endfunction

  // driver: hold the transaction until taken, then load the next one or idle
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        expected_points.push_back(integrate_point(point_on_bus, dt_model));
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (point_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          point_on_bus <= point_queue[0];
          in_ch.rotation_in <= point_queue[0].rot;
          in_ch.ang_vel_x <= point_queue[0].w[0];
          in_ch.ang_vel_y <= point_queue[0].w[1];
          in_ch.ang_vel_z <= point_queue[0].w[2];
          in_ch.torque_x <= point_queue[0].tq[0];
          in_ch.torque_y <= point_queue[0].tq[1];
          in_ch.torque_z <= point_queue[0].tq[2];
          in_ch.inertia_x <= point_queue[0].iner[0];
          in_ch.inertia_y <= point_queue[0].iner[1];
          in_ch.inertia_z <= point_queue[0].iner[2];
          in_ch.pinned <= point_queue[0].pinned;
          in_ch.valid <= 1'b1;
          void'(point_queue.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cfg_ch.valid && cfg_ch.ready) dt_model <= cfg_ch.sub_step_time;
  end

  // monitor
  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n) begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result rot=%h", $time, out_ch.rotation_out);
          errors++;
        end else begin
          exp_r = expected_points.pop_front();
          if (out_ch.rotation_out !== exp_r.rot) begin
            $display("%0t: rotation_out expected %h actual %h", $time, exp_r.rot,
                     out_ch.rotation_out);
            errors++;
          end
          if (out_ch.new_ang_vel_x !== exp_r.w[0] || out_ch.new_ang_vel_y !== exp_r.w[1] ||
              out_ch.new_ang_vel_z !== exp_r.w[2]) begin
            $display("%0t: new_ang_vel expected %h %h %h actual %h %h %h", $time,
                     exp_r.w[0], exp_r.w[1], exp_r.w[2], out_ch.new_ang_vel_x,
                     out_ch.new_ang_vel_y, out_ch.new_ang_vel_z);
            errors++;
          end
          if (out_ch.skipped !== exp_r.skipped) begin
            $display("%0t: skipped expected %b actual %b", $time, exp_r.skipped,
                     out_ch.skipped);
            errors++;
          end
        end
      end
    end
  end

  function automatic logic [31:0] pick_vec();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(131072)) - 65536);
      2: return 32'($signed($urandom_range(8388608)) - 4194304);
      default: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_inertia();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return $urandom;
      2: return $urandom_range(4);
      3: return 32'hFFFF_FFFF;
      default: return $urandom_range(1 << 20, 1 << 12);
    endcase
  endfunction

  function automatic point_t random_point();
    point_t p;
    if ($urandom_range(2) == 0) p.rot = {$urandom, $urandom};
    else begin
      for (int i = 0; i < 4; i++)
        p.rot[63 - 16 * i -: 16] = 16'($signed($urandom_range(32768)) - 16384);
    end
    for (int i = 0; i < 3; i++) begin
      p.w[i] = pick_vec();
      p.tq[i] = pick_vec();
      p.iner[i] = pick_inertia();
    end
    p.pinned = ($urandom_range(7) == 0);
    return p;
  endfunction

  task automatic write_dt(input logic [31:0] v);
    @(posedge clk);
    cfg_ch.sub_step_time <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (point_queue.size() != 0 || in_ch.valid || expected_points.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int n, input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int k = 0; k < n; k++) point_queue.push_back(random_point());
    drain();
  endtask

  initial begin
    point_t p;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed points at the reset substep
    p.rot = {Q14_ONE, 48'd0};
    p.w = {32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
    p.tq = {32'h0002_0000, 32'd0, 32'hFFFE_0000};
    p.iner = {32'h0001_0000, 32'h0002_0000, 32'h0000_8000};
    p.pinned = 1'b0;
    point_queue.push_back(p);
    p.pinned = 1'b1;
    point_queue.push_back(p);
    p.pinned = 1'b0;
    p.iner = '0;
    point_queue.push_back(p);
    p.iner = {32'h0001_0000, 32'd0, 32'h0003_0000};
    point_queue.push_back(p);
    p.iner = {32'd1, 32'hFFFF_FFFF, 32'd1};
    point_queue.push_back(p);
    p.rot = '0;
    p.w = '0;
    p.tq = '0;
    point_queue.push_back(p);
    p.rot = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
    p.w = {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    p.tq = {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    p.iner = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    point_queue.push_back(p);
    p.iner = {32'd1, 32'd1, 32'd1};
    point_queue.push_back(p);
    p.rot = {16'h2000, 16'h1000, 16'hF000, 16'h0800};
    p.w = {32'h0000_4000, 32'h0003_0000, 32'hFFFC_0000};
    p.tq = '0;
    p.iner = {32'h0000_0100, 32'h0010_0000, 32'h0000_0001};
    point_queue.push_back(p);
    p.rot = '1;
    p.w = '1;
    p.tq = '1;
    p.iner = '1;
    point_queue.push_back(p);
    drain();
    random_phase(150, 0, 0);

    write_dt(32'hFFFF_FFFF);
    random_phase(150, 65, 0);
    write_dt(32'd0);
    random_phase(150, 0, 65);
    write_dt(32'h0001_0000);
    random_phase(150, 14, 14);
    write_dt($urandom_range(65535));
    random_phase(200, 0, 0);

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rpai_pkg.sv
hw/rtl/rpai_cfg_if.sv
hw/rtl/rpai_in_if.sv
hw/rtl/rpai_out_if.sv
hw/rtl/rigid_point_angular_integrator_top.sv
sim/testbench.sv
